// ----- rtl/qmm_pkg.sv -----
// Package for the quad motor mixer: field widths, command and result structs,
// configuration register indexes and the cross-layout scaling constant.
// No dependencies.
package qmm_pkg;

  // Default number of fraction bits (1.0 = 2**FRAC_BITS)
  localparam int FRAC_BITS_DEF = 14;

  // Field widths
  localparam int THR_W  = 15;
  localparam int ADJ_W  = 16;
  localparam int CMP_W  = 16;
  localparam int BASE_W = 15;

  // Motor sums before normalization fit in 18 bits signed
  localparam int SUM_W = 18;

  // Four motors, one lane each
  localparam int LANES = 4;

  // Cross layout factor 11585/16384 (about 1/sqrt(2)), floor rounding
  localparam int DIAG_W = 15;
  localparam logic signed [DIAG_W-1:0] DIAG_NUM = 15'sd11585;
  localparam int DIAG_SHIFT  = 14;
  localparam int DIAG_PROD_W = ADJ_W + DIAG_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BASE_W;
  localparam logic [CFG_IDX_W-1:0] REG_PLUS_LAYOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_BASE  = 1'd1;

  typedef struct packed {
    logic        [THR_W-1:0] throttle;
    logic signed [ADJ_W-1:0] roll_adj;
    logic signed [ADJ_W-1:0] pitch_adj;
    logic signed [ADJ_W-1:0] yaw_adj;
  } qmm_cmd_t;

  typedef struct packed {
    logic [CMP_W-1:0] motor1_compare;
    logic [CMP_W-1:0] motor2_compare;
    logic [CMP_W-1:0] motor3_compare;
    logic [CMP_W-1:0] motor4_compare;
  } qmm_res_t;

endpackage

// ----- rtl/qmm_div.sv -----
// Pipelined four-lane restoring divider: quot = floor(dividend * 2**FRAC_BITS / divisor),
// one quotient bit per stage, all lanes share one divisor (dividend <= divisor).
// Depends on qmm_pkg.
module qmm_div #(
  parameter int FRAC_BITS = qmm_pkg::FRAC_BITS_DEF,
  parameter int VAL_W     = qmm_pkg::SUM_W
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  input  logic [VAL_W-1:0]                            divisor,
  input  logic [qmm_pkg::LANES-1:0][VAL_W-1:0]        dividend,
  output logic                                        out_valid,
  output logic [qmm_pkg::LANES-1:0][FRAC_BITS:0]      quot
);
  import qmm_pkg::*;

  localparam int NSTG = FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [LANES-1:0][VAL_W-1:0]   rem [NSTG+1];
  logic [LANES-1:0][FRAC_BITS:0] qt  [NSTG+1];
  logic [VAL_W-1:0]              dvs [NSTG+1];
  logic                          vld [NSTG+1];

  assign rem[0] = dividend;
  assign qt[0]  = '0;
  assign dvs[0] = divisor;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [VAL_W:0]   trial [LANES];
    logic [LANES-1:0] take;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        // first step compares the dividend itself, later steps shift in a zero
        if (s == 0) begin
          trial[l] = {1'b0, rem[s][l]};
        end else begin
          trial[l] = {rem[s][l], 1'b0};
        end
        take[l] = trial[l] >= {1'b0, dvs[s]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      dvs[s+1] <= dvs[s];
      for (int l = 0; l < LANES; l++) begin
        if (take[l]) begin
          rem[s+1][l] <= VAL_W'(trial[l] - {1'b0, dvs[s]});
        end else begin
          rem[s+1][l] <= VAL_W'(trial[l]);
        end
        qt[s+1][l] <= {qt[s][l][FRAC_BITS-1:0], take[l]};
      end
    end
  end

  assign out_valid = vld[NSTG];
  assign quot      = qt[NSTG];

  logic quot_in_range;
  always_comb begin
    quot_in_range = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      if (quot[l] > ONE_Q) begin
        quot_in_range = 1'b0;
      end
    end
  end

  // Dividend never exceeds divisor, so no quotient passes 1.0
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quot_in_range)
    else $error("qmm_div: quotient above 1.0");

endmodule

// ----- rtl/quad_motor_mixer_core.sv -----
// Top level of the quad motor mixer: mixing, normalization, divider and
// PWM compare scaling in one stall-free pipeline.
// Depends on qmm_pkg and qmm_div.
//
// Quad motor mixer. Each request carries throttle, roll, pitch and yaw in
// fixed point (1.0 = 2**FRAC_BITS) and produces one set of four motor PWM
// compare values. The block takes one request every clock cycle: busy is high
// only while rst is held, so a request is taken at every edge where start is
// high and rst is low. The result appears on result with done high for exactly
// one cycle, in request order. The receiver cannot stall the block and must
// take every result in its done cycle. The normalizing divider produces one
// quotient bit per pipeline stage (FRAC_BITS + 1 stages); around it sit four
// stages for the cross-layout scaling, the motor sums, the negative shift and
// the largest-value search, and two for the final pulse_base scaling. Write
// plus_layout and pulse_base only while no request is in flight; they are read
// live by the pipeline.
module quad_motor_mixer_core #(
  parameter int FRAC_BITS = qmm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  qmm_pkg::qmm_cmd_t                 cmd,
  output logic                              done,
  output qmm_pkg::qmm_res_t                 result,
  input  logic                              cfg_write,
  input  logic [qmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qmm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import qmm_pkg::*;

  // Normalized values need room for both the raw spread and 1.0 itself
  localparam int VAL_W   = (FRAC_BITS + 1 > SUM_W) ? FRAC_BITS + 1 : SUM_W;
  localparam int PROD_W  = BASE_W + FRAC_BITS + 1;
  localparam int LATENCY = FRAC_BITS + 7;
  localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic              plus_layout;
  logic [BASE_W-1:0] pulse_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_layout <= 1'b1;
      pulse_base  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PLUS_LAYOUT: plus_layout <= cfg_data[0];
        REG_PULSE_BASE:  pulse_base  <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Never refuse a request except while in reset
  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Valid chain (control state, cleared by reset)
  // ---------------------------------------------------------------------------
  logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld;
  logic q_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      s1_vld <= accept;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= q_vld;
      done   <= s5_vld;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the request, scale pitch and roll for the cross layout
  // (floor of adj * 11585 / 16384, arithmetic shift rounds toward -inf)
  // ---------------------------------------------------------------------------
  logic signed [DIAG_PROD_W-1:0] pitch_prod, roll_prod;
  logic        [THR_W-1:0]       s1_thr;
  logic signed [ADJ_W-1:0]       s1_roll, s1_pitch, s1_yaw, s1_pdiag, s1_rdiag;

  assign pitch_prod = DIAG_PROD_W'(cmd.pitch_adj) * DIAG_PROD_W'(DIAG_NUM);
  assign roll_prod  = DIAG_PROD_W'(cmd.roll_adj)  * DIAG_PROD_W'(DIAG_NUM);

  always_ff @(posedge clk) begin
    s1_thr   <= cmd.throttle;
    s1_roll  <= cmd.roll_adj;
    s1_pitch <= cmd.pitch_adj;
    s1_yaw   <= cmd.yaw_adj;
    s1_pdiag <= ADJ_W'(pitch_prod >>> DIAG_SHIFT);
    s1_rdiag <= ADJ_W'(roll_prod  >>> DIAG_SHIFT);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: motor sums. Yaw adds to motors 1 and 3, subtracts from 2 and 4.
  // Plus: pitch on 1/3, roll on 4/2. Cross: both split across motor pairs.
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] mix_next [LANES];
  logic signed [SUM_W-1:0] s2_mix   [LANES];

  always_comb begin
    logic signed [SUM_W-1:0] t, y, pt, rl;
    t = SUM_W'($signed({1'b0, s1_thr}));
    y = SUM_W'(s1_yaw);
    if (plus_layout) begin
      pt = SUM_W'(s1_pitch);
      rl = SUM_W'(s1_roll);
      mix_next[0] = t + y + pt;
      mix_next[1] = t - y - rl;
      mix_next[2] = t + y - pt;
      mix_next[3] = t - y + rl;
    end else begin
      pt = SUM_W'(s1_pdiag);
      rl = SUM_W'(s1_rdiag);
      mix_next[0] = t + y + pt + rl;
      mix_next[1] = t - y + pt - rl;
      mix_next[2] = t + y - pt - rl;
      mix_next[3] = t - y - pt + rl;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      s2_mix[l] <= mix_next[l];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: lift all four by the most negative sum so none is below zero
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][VAL_W-1:0] shift_next;
  logic [LANES-1:0][VAL_W-1:0] s3_v;

  always_comb begin
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W:0]   diff;
    lo = '0;
    for (int l = 0; l < LANES; l++) begin
      if (s2_mix[l] < lo) begin
        lo = s2_mix[l];
      end
    end
    for (int l = 0; l < LANES; l++) begin
      diff = (SUM_W+1)'(s2_mix[l]) - (SUM_W+1)'(lo);
      shift_next[l] = VAL_W'($unsigned(diff));
    end
  end

  always_ff @(posedge clk) begin
    s3_v <= shift_next;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: divisor = max(1.0, largest value). Dividing by exactly 1.0 leaves
  // a value unchanged, so the divider runs on every request.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0]            hi_next;
  logic [VAL_W-1:0]            s4_dvs;
  logic [LANES-1:0][VAL_W-1:0] s4_v;

  always_comb begin
    hi_next = ONE;
    for (int l = 0; l < LANES; l++) begin
      if (s3_v[l] > hi_next) begin
        hi_next = s3_v[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    s4_dvs <= hi_next;
    s4_v   <= s3_v;
  end

  // ---------------------------------------------------------------------------
  // Normalizing divider, FRAC_BITS + 1 stages
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][FRAC_BITS:0] q;

  qmm_div #(
    .FRAC_BITS (FRAC_BITS),
    .VAL_W     (VAL_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_vld),
    .divisor   (s4_dvs),
    .dividend  (s4_v),
    .out_valid (q_vld),
    .quot      (q)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: pulse_base * value
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] s5_prod [LANES];

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      s5_prod[l] <= PROD_W'(pulse_base) * PROD_W'(q[l]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: compare = pulse_base + floor(pulse_base * value / 1.0)
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] cmp_next [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cmp_next[l] = CMP_W'(pulse_base) + CMP_W'(s5_prod[l] >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    result.motor1_compare <= cmp_next[0];
    result.motor2_compare <= cmp_next[1];
    result.motor3_compare <= cmp_next[2];
    result.motor4_compare <= cmp_next[3];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // After the shift step no value may exceed the chosen divisor
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    s4_vld |-> (s4_v[0] <= s4_dvs) && (s4_v[1] <= s4_dvs) &&
               (s4_v[2] <= s4_dvs) && (s4_v[3] <= s4_dvs) && (s4_dvs >= ONE))
    else $error("mixer: value above divisor or divisor below 1.0");

  // Every accepted request yields its result with done high
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("mixer: request dropped");

  // No result without an earlier accepted request
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("mixer: result without request");

endmodule
